// ===== hdl/iee_pkg.sv =====
// Shared types, constants and helpers for the infix expression evaluator.
// Used by every module of the block; depends on nothing.
package iee_pkg;

   localparam int VALUE_W = 48;

   localparam logic [VALUE_W-1:0] MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] MIN_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_MUL  = 2'd1;
   localparam logic [1:0] PEND_DIV  = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      div_by_zero;
      logic                      overflow;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CC_DIGIT  = 2'd0,
      CC_ADDSUB = 2'd1,
      CC_MULDIV = 2'd2,
      CC_OTHER  = 2'd3
   } char_class_type;

   typedef enum logic [3:0] {
      CMD_NONE        = 4'd0,
      CMD_CAPTURE     = 4'd1,
      CMD_DIG_SCALE   = 4'd2,
      CMD_DIG_ADD     = 4'd3,
      CMD_MD_START    = 4'd4,
      CMD_TERM_FACTOR = 4'd5,
      CMD_TERM_MD     = 4'd6,
      CMD_MD_SET      = 4'd7,
      CMD_OPND_FACTOR = 4'd8,
      CMD_OPND_MD     = 4'd9,
      CMD_SUM_ADD     = 4'd10,
      CMD_PM_CLEAR    = 4'd11,
      CMD_PM_SIGN     = 4'd12,
      CMD_CHAR_END    = 4'd13,
      CMD_EMIT        = 4'd14
   } dp_cmd_type;

   typedef struct packed {
      char_class_type char_class;
      logic           is_last;
      logic           prev_muldiv;
      logic           term_active;
      logic           pend_none;
      logic           md_done;
      logic           rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic                      done;
      logic signed [VALUE_W-1:0] value;
      logic                      overflow;
      logic                      div_zero;
   } md_status_type;

   function automatic char_class_type classify_char(input logic [7:0] c);
      char_class_type cls;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         cls = CC_DIGIT;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         cls = CC_ADDSUB;
      end else if (c == CHAR_STAR || c == CHAR_SLASH) begin
         cls = CC_MULDIV;
      end else begin
         cls = CC_OTHER;
      end
      return cls;
   endfunction

endpackage

// ===== hdl/iee_muldiv.sv =====
// Iterative saturating fixed-point multiply (shift-add) and divide (restoring).
// Depends on iee_pkg for widths, limits and the status struct.
module iee_muldiv import iee_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 is_div,
   input  logic [VALUE_W-1:0]   a,
   input  logic [VALUE_W-1:0]   b,
   output md_status_type        status
);

   localparam int W     = VALUE_W;
   localparam int ND    = VALUE_W + FRAC_BITS;
   localparam int PW    = 2 * VALUE_W;
   localparam int CNT_W = $clog2(ND + 1);

   typedef enum logic [4:0] {
      M_IDLE = 5'b00001,
      M_PREP = 5'b00010,
      M_RUN  = 5'b00100,
      M_FIN  = 5'b01000,
      M_DONE = 5'b10000
   } md_state_type;

   md_state_type     state_ff, state_in;
   logic [W-1:0]     a_ff, a_in, b_ff, b_in;
   logic             div_ff, div_in, neg_ff, neg_in, dz_ff, dz_in;
   logic [W-1:0]     mcand_ff, mcand_in, divisor_ff, divisor_in, rem_ff, rem_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [ND-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     value_ff, value_in;
   logic             ovf_ff, ovf_in;

   logic [W-1:0]     ma, mb, lim, clamp;
   logic             b_zero, over;
   logic [W:0]       msum, rshift, rdiff;
   logic             ge;
   logic [PW-1:0]    mag_wide;

   always_comb begin
      ma       = a_ff[W-1] ? ('0 - a_ff) : a_ff;
      mb       = b_ff[W-1] ? ('0 - b_ff) : b_ff;
      b_zero   = (b_ff == '0);
      msum     = {1'b0, prod_ff[PW-1:W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      rshift   = {rem_ff, quo_ff[ND-1]};
      rdiff    = rshift - {1'b0, divisor_ff};
      ge       = (rshift >= {1'b0, divisor_ff});
      mag_wide = div_ff ? PW'(quo_ff) : (prod_ff >> FRAC_BITS);
      lim      = MAX_POS + W'(neg_ff);
      over     = (mag_wide > PW'(lim));
      clamp    = over ? lim : mag_wide[W-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      div_in     = div_ff;
      neg_in     = neg_ff;
      dz_in      = dz_ff;
      mcand_in   = mcand_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      prod_in    = prod_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      value_in   = value_ff;
      ovf_in     = ovf_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               a_in     = a;
               b_in     = b;
               div_in   = is_div;
               state_in = M_PREP;
            end
         end
         M_PREP: begin
            neg_in = a_ff[W-1] ^ b_ff[W-1];
            dz_in  = div_ff & b_zero;
            if (div_ff) begin
               quo_in     = ND'(ma) << FRAC_BITS;
               rem_in     = '0;
               divisor_in = mb;
               cnt_in     = CNT_W'(ND);
            end else begin
               prod_in  = PW'(mb);
               mcand_in = ma;
               cnt_in   = CNT_W'(W);
            end
            state_in = (div_ff & b_zero) ? M_FIN : M_RUN;
         end
         M_RUN: begin
            if (div_ff) begin
               rem_in = ge ? rdiff[W-1:0] : rshift[W-1:0];
               quo_in = {quo_ff[ND-2:0], ge};
            end else begin
               prod_in = {msum, prod_ff[W-1:1]};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = M_FIN;
            end
         end
         M_FIN: begin
            if (dz_ff) begin
               value_in = a_ff[W-1] ? MIN_NEG : MAX_POS;
               ovf_in   = 1'b0;
            end else begin
               value_in = neg_ff ? ('0 - clamp) : clamp;
               ovf_in   = over;
            end
            state_in = M_DONE;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      div_ff     <= div_in;
      neg_ff     <= neg_in;
      dz_ff      <= dz_in;
      mcand_ff   <= mcand_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      value_ff   <= value_in;
      ovf_ff     <= ovf_in;
   end

   assign status.done     = (state_ff == M_DONE);
   assign status.value    = value_ff;
   assign status.overflow = ovf_ff;
   assign status.div_zero = dz_ff;

endmodule

// ===== hdl/iee_datapath.sv =====
// Evaluator datapath: expression state, saturating adders, result register.
// Depends on iee_pkg and instantiates iee_muldiv.
module iee_datapath import iee_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_stall
);

   localparam int W  = VALUE_W;
   localparam int EW = VALUE_W + 4;

   logic [7:0]      char_ff, char_in;
   logic            last_ff, last_in;
   logic [W-1:0]    sum_ff, sum_in, num_ff, num_in, term_ff, term_in, opnd_ff, opnd_in;
   logic            active_ff, active_in, neg_ff, neg_in, prev_ff, prev_in;
   logic [1:0]      pend_ff, pend_in;
   logic            dz_ff, dz_in, ovf_ff, ovf_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [W-1:0]    factor;
   logic [EW-1:0]   n10, dsc;
   logic            n10_over, dsc_over;
   logic [3:0]      dval;
   logic [W:0]      dsum, ssum;
   logic            dsum_over, ssum_over;
   logic [W-1:0]    ssat;
   md_status_type   md;

   iee_muldiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd == CMD_MD_START),
      .is_div (pend_ff == PEND_DIV),
      .a      (term_ff),
      .b      (factor),
      .status (md)
   );

   always_comb begin
      factor    = neg_ff ? ('0 - num_ff) : num_ff;
      n10       = (EW'(num_ff) << 3) + (EW'(num_ff) << 1);
      n10_over  = (n10 > EW'(MAX_POS));
      dval      = 4'(char_ff - CHAR_0);
      dsc       = EW'(dval) << FRAC_BITS;
      dsc_over  = (dsc > EW'(MAX_POS));
      dsum      = {1'b0, num_ff} + {1'b0, opnd_ff};
      dsum_over = (dsum > {1'b0, MAX_POS});
      ssum      = {sum_ff[W-1], sum_ff} + {opnd_ff[W-1], opnd_ff};
      ssum_over = ssum[W] ^ ssum[W-1];
      ssat      = ssum_over ? (ssum[W] ? MIN_NEG : MAX_POS) : ssum[W-1:0];
   end

   always_comb begin
      char_in        = char_ff;
      last_in        = last_ff;
      sum_in         = sum_ff;
      num_in         = num_ff;
      term_in        = term_ff;
      opnd_in        = opnd_ff;
      active_in      = active_ff;
      neg_in         = neg_ff;
      prev_in        = prev_ff;
      pend_in        = pend_ff;
      dz_in          = dz_ff;
      ovf_in         = ovf_ff;
      rsp_payload_in = rsp_payload_ff;
      // drop the held result once it transfers
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      case (cmd)
         CMD_CAPTURE: begin
            char_in = req_payload.char_code;
            last_in = req_payload.last;
         end
         CMD_DIG_SCALE: begin
            num_in  = n10_over ? MAX_POS : n10[W-1:0];
            opnd_in = dsc_over ? MAX_POS : dsc[W-1:0];
            ovf_in  = ovf_ff | n10_over | dsc_over;
         end
         CMD_DIG_ADD: begin
            num_in = dsum_over ? MAX_POS : dsum[W-1:0];
            ovf_in = ovf_ff | dsum_over;
         end
         CMD_TERM_FACTOR: begin
            term_in = factor;
         end
         CMD_TERM_MD: begin
            term_in = md.value;
            ovf_in  = ovf_ff | md.overflow;
            dz_in   = dz_ff | md.div_zero;
         end
         CMD_MD_SET: begin
            active_in = 1'b1;
            pend_in   = (char_ff == CHAR_STAR) ? PEND_MUL : PEND_DIV;
            num_in    = '0;
            neg_in    = 1'b0;
         end
         CMD_OPND_FACTOR: begin
            opnd_in = factor;
         end
         CMD_OPND_MD: begin
            opnd_in = md.value;
            ovf_in  = ovf_ff | md.overflow;
            dz_in   = dz_ff | md.div_zero;
         end
         CMD_SUM_ADD: begin
            sum_in = ssat;
            ovf_in = ovf_ff | ssum_over;
         end
         CMD_PM_CLEAR: begin
            term_in   = '0;
            active_in = 1'b0;
            pend_in   = PEND_NONE;
            num_in    = '0;
            neg_in    = (char_ff == CHAR_MINUS);
         end
         CMD_PM_SIGN: begin
            neg_in = (char_ff == CHAR_MINUS);
         end
         CMD_CHAR_END: begin
            prev_in = (classify_char(char_ff) == CC_MULDIV);
         end
         CMD_EMIT: begin
            rsp_payload_in.value       = sum_ff;
            rsp_payload_in.div_by_zero = dz_ff;
            rsp_payload_in.overflow    = ovf_ff;
            rsp_valid_in               = 1'b1;
            sum_in    = '0;
            num_in    = '0;
            term_in   = '0;
            active_in = 1'b0;
            pend_in   = PEND_NONE;
            neg_in    = 1'b0;
            prev_in   = 1'b0;
            dz_in     = 1'b0;
            ovf_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         num_ff       <= '0;
         term_ff      <= '0;
         active_ff    <= 1'b0;
         neg_ff       <= 1'b0;
         prev_ff      <= 1'b0;
         pend_ff      <= PEND_NONE;
         dz_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         num_ff       <= num_in;
         term_ff      <= term_in;
         active_ff    <= active_in;
         neg_ff       <= neg_in;
         prev_ff      <= prev_in;
         pend_ff      <= pend_in;
         dz_ff        <= dz_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff        <= char_in;
      last_ff        <= last_in;
      opnd_ff        <= opnd_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign status.char_class  = classify_char(char_ff);
   assign status.is_last     = last_ff;
   assign status.prev_muldiv = prev_ff;
   assign status.term_active = active_ff;
   assign status.pend_none   = (pend_ff == PEND_NONE);
   assign status.md_done     = md.done;
   assign status.rsp_free    = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hdl/iee_ctrl.sv =====
// Evaluator controller: one-hot sequencer that issues datapath commands.
// Depends on iee_pkg for the command and status types.
module iee_ctrl import iee_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b00000000001,
      ST_DECODE    = 11'b00000000010,
      ST_DIG_ADD   = 11'b00000000100,
      ST_MD_WAIT   = 11'b00000001000,
      ST_MD_SET    = 11'b00000010000,
      ST_FOLD      = 11'b00000100000,
      ST_FOLD_WAIT = 11'b00001000000,
      ST_SUM_ADD   = 11'b00010000000,
      ST_PM_CLEAR  = 11'b00100000000,
      ST_CHAR_END  = 11'b01000000000,
      ST_EMIT      = 11'b10000000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           emit_fold_ff, emit_fold_in;

   always_comb begin
      state_in     = state_ff;
      emit_fold_in = emit_fold_ff;
      cmd          = CMD_NONE;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd          = CMD_CAPTURE;
               emit_fold_in = 1'b0;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.char_class)
               CC_DIGIT: begin
                  cmd      = CMD_DIG_SCALE;
                  state_in = ST_DIG_ADD;
               end
               CC_ADDSUB: begin
                  if (status.prev_muldiv) begin
                     cmd      = CMD_PM_SIGN;
                     state_in = ST_CHAR_END;
                  end else begin
                     state_in = ST_FOLD;
                  end
               end
               CC_MULDIV: begin
                  if (status.term_active) begin
                     cmd      = CMD_MD_START;
                     state_in = ST_MD_WAIT;
                  end else begin
                     cmd      = CMD_TERM_FACTOR;
                     state_in = ST_MD_SET;
                  end
               end
               default: begin
                  state_in = ST_CHAR_END;
               end
            endcase
         end
         ST_DIG_ADD: begin
            cmd      = CMD_DIG_ADD;
            state_in = ST_CHAR_END;
         end
         ST_MD_WAIT: begin
            if (status.md_done) begin
               cmd      = CMD_TERM_MD;
               state_in = ST_MD_SET;
            end
         end
         ST_MD_SET: begin
            cmd      = CMD_MD_SET;
            state_in = ST_CHAR_END;
         end
         ST_FOLD: begin
            if (status.pend_none) begin
               cmd      = CMD_OPND_FACTOR;
               state_in = ST_SUM_ADD;
            end else begin
               cmd      = CMD_MD_START;
               state_in = ST_FOLD_WAIT;
            end
         end
         ST_FOLD_WAIT: begin
            if (status.md_done) begin
               cmd      = CMD_OPND_MD;
               state_in = ST_SUM_ADD;
            end
         end
         ST_SUM_ADD: begin
            cmd      = CMD_SUM_ADD;
            state_in = emit_fold_ff ? ST_EMIT : ST_PM_CLEAR;
         end
         ST_PM_CLEAR: begin
            cmd      = CMD_PM_CLEAR;
            state_in = ST_CHAR_END;
         end
         ST_CHAR_END: begin
            cmd = CMD_CHAR_END;
            if (status.is_last) begin
               emit_fold_in = 1'b1;
               state_in     = ST_FOLD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd          = CMD_EMIT;
               emit_fold_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         emit_fold_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_fold_ff <= emit_fold_in;
      end
   end

endmodule

// ===== hdl/infix_expression_evaluator.sv =====
// Infix expression evaluator: takes one ASCII character per transfer and, on
// the character flagged last, returns the value of the expression in signed
// fixed point (VALUE_W bits, FRAC_BITS fractional bits) with sticky
// divide-by-zero and overflow flags. Digits build a number, * and / bind
// tighter than + and -, a sign straight after * or / applies to the next
// factor, and any other character is skipped. Every result saturates. The
// block works on one character at a time and stalls its input until the
// character is finished. An ignored character, a sign straight after * or /,
// a digit, a * or / that opens a term, and a + or - with no product or
// quotient pending leave the multiply/divide unit alone; a * or / that
// combines with an earlier factor, and a + or - that closes a product or
// quotient, wait for the shared iterative multiply/divide unit, which
// runs longer on a divide than on a multiply. The last character then adds
// its final fold, the last step of which loads the result register. The
// result sits in that output register, so the next expression may start
// while the previous result waits to transfer; a further result is held
// back, and the input with it, until the register frees up.
// Depends on iee_pkg, iee_ctrl, iee_datapath and iee_muldiv.
module infix_expression_evaluator import iee_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: holds the input while a character is in work
   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // expression state, arithmetic and the result register
   iee_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

// ===== tb/infix_expression_evaluator_tb.sv =====
// Testbench for infix_expression_evaluator: drives character transfers and
// checks each expression result against a local fixed-point evaluator.
// Depends on iee_pkg and the infix_expression_evaluator RTL.
`timescale 1ns / 1ps

module infix_expression_evaluator_tb;
   import iee_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int ITEM_TARGET = 850;
   localparam int HOLD_CYCLES = 1000;     // long receiver hold-off to back the block up
   localparam int DRAIN_WAIT  = 400;      // covers a last character plus its fold
   localparam int CYCLE_LIMIT = 1000000;

   localparam logic [127:0] MAG_MAX = 128'(MAX_POS);
   localparam rsp_payload_type NO_RSP = '0;

   typedef logic signed [VALUE_W-1:0] fixed_type;
   typedef logic [7:0] char_q_type [$];

   // One row of the directed part: the character, its end-of-expression mark, and
   // a hand-written result where one can be read straight off.
   typedef struct packed {
      logic [7:0]      code;
      logic            is_last;
      logic            typed;
      rsp_payload_type want;
   } probe_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Hand-written expectation travelling alongside the character on offer.
   logic            cur_typed = 1'b0;
   rsp_payload_type cur_want = '0;

   // Idle percentages of the current phase and the pressure request.
   int   send_idle_pct = 30;
   int   take_idle_pct = 72;
   logic hold_ask = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;

   int   fails = 0;
   int   cycle_count = 0;

   // Evaluator state, mirroring what the block keeps between characters.
   fixed_type  sum_acc = '0;
   fixed_type  number_acc = '0;
   fixed_type  term_acc = '0;
   logic       term_open = 1'b0;
   logic [1:0] pend_op = PEND_NONE;
   logic       negate_factor = 1'b0;
   logic       after_muldiv = 1'b0;
   logic       div_zero_seen = 1'b0;
   logic       overflow_seen = 1'b0;

   rsp_payload_type expression_values [$];
   probe_type       probes [28];

   infix_expression_evaluator #(.FRAC_BITS(FRAC_BITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Fixed-point evaluator. Work on magnitudes in 128 bits, then clamp to the
   // signed range; a clamp marks the expression as overflowed.
   // ---------------------------------------------------------------------------
   function automatic logic [127:0] mag_abs(input fixed_type x);
      logic signed [127:0] wide;
      wide = x;
      return (wide < 0) ? -wide : wide;
   endfunction

   function automatic fixed_type clamp_mag(input logic neg, input logic [127:0] m);
      logic [127:0] lim;
      lim = MAG_MAX + (neg ? 128'd1 : 128'd0);
      if (m > lim) begin
         overflow_seen = 1'b1;
         m = lim;
      end
      return neg ? fixed_type'(-m) : fixed_type'(m);
   endfunction

   function automatic fixed_type clamp_signed(input logic signed [127:0] v);
      return clamp_mag(v < 0, (v < 0) ? -v : v);
   endfunction

   function automatic fixed_type add_sat(input fixed_type a, input fixed_type b);
      logic signed [127:0] total;
      total = a;
      total = total + b;
      return clamp_signed(total);
   endfunction

   function automatic fixed_type negate_sat(input fixed_type x);
      logic signed [127:0] total;
      total = x;
      return clamp_signed(-total);
   endfunction

   // Products and quotients truncate towards zero: work on magnitudes.
   function automatic fixed_type mul_sat(input fixed_type a, input fixed_type b);
      return clamp_mag(a[VALUE_W-1] ^ b[VALUE_W-1],
                       (mag_abs(a) * mag_abs(b)) >> FRAC_BITS);
   endfunction

   function automatic fixed_type div_sat(input fixed_type a, input fixed_type b);
      if (b == '0) begin
         // a zero divisor saturates by the dividend's sign, without overflow
         div_zero_seen = 1'b1;
         return a[VALUE_W-1] ? fixed_type'(MIN_NEG) : fixed_type'(MAX_POS);
      end
      return clamp_mag(a[VALUE_W-1] ^ b[VALUE_W-1],
                       (mag_abs(a) << FRAC_BITS) / mag_abs(b));
   endfunction

   function automatic fixed_type next_factor();
      return negate_factor ? negate_sat(number_acc) : number_acc;
   endfunction

   // Close the current term (plain factor, product or quotient) into the sum.
   function automatic void fold_term();
      fixed_type f;
      fixed_type t;
      f = next_factor();
      if (pend_op == PEND_MUL) begin
         t = mul_sat(term_acc, f);
      end else if (pend_op == PEND_DIV) begin
         t = div_sat(term_acc, f);
      end else begin
         t = f;
      end
      sum_acc = add_sat(sum_acc, t);
   endfunction

   // Advance the evaluator by one accepted character; on the last one, queue
   // the expression's value (or the hand-written one) and clear all state.
   function automatic void evaluate_char(input logic [7:0] code, input logic is_last,
                                         input logic typed, input rsp_payload_type want);
      fixed_type       f;
      logic [127:0]    digit;
      logic            hit_muldiv;
      rsp_payload_type value_out;
      hit_muldiv = 1'b0;
      if (code >= CHAR_0 && code <= CHAR_9) begin
         digit = code - CHAR_0;
         number_acc = clamp_mag(1'b0, mag_abs(number_acc) * 10);
         number_acc = add_sat(number_acc, clamp_mag(1'b0, digit << FRAC_BITS));
      end else if (code == CHAR_PLUS || code == CHAR_MINUS) begin
         // straight after * or / a sign only marks the next factor
         if (!after_muldiv) begin
            fold_term();
            term_acc   = '0;
            term_open  = 1'b0;
            pend_op    = PEND_NONE;
            number_acc = '0;
         end
         negate_factor = (code == CHAR_MINUS);
      end else if (code == CHAR_STAR || code == CHAR_SLASH) begin
         f = next_factor();
         if (!term_open) begin
            term_acc = f;
         end else if (pend_op == PEND_DIV) begin
            term_acc = div_sat(term_acc, f);
         end else begin
            term_acc = mul_sat(term_acc, f);
         end
         term_open     = 1'b1;
         pend_op       = (code == CHAR_STAR) ? PEND_MUL : PEND_DIV;
         number_acc    = '0;
         negate_factor = 1'b0;
         hit_muldiv    = 1'b1;
      end
      after_muldiv = hit_muldiv;

      if (is_last) begin
         fold_term();
         value_out.value       = sum_acc;
         value_out.div_by_zero = div_zero_seen;
         value_out.overflow    = overflow_seen;
         expression_values.push_back(typed ? want : value_out);
         sum_acc       = '0;
         number_acc    = '0;
         term_acc      = '0;
         term_open     = 1'b0;
         pend_op       = PEND_NONE;
         negate_factor = 1'b0;
         after_muldiv  = 1'b0;
         div_zero_seen = 1'b0;
         overflow_seen = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------------
   function automatic logic [7:0] random_sign();
      return $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
   endfunction

   // Well-formed expression: terms joined by + or -, factors by * or /, an
   // occasional sign after * or /, long numbers now and then to force
   // saturation, and the odd stray character.
   function automatic char_q_type random_expression();
      char_q_type s;
      int terms;
      int factors;
      int digits;
      int t;
      int f;
      terms = $urandom_range(1, 4);
      for (t = 0; t < terms; t++) begin
         if (t > 0 || $urandom_range(5) == 0) s.push_back(random_sign());
         factors = $urandom_range(1, 3);
         for (f = 0; f < factors; f++) begin
            if (f > 0) begin
               s.push_back($urandom_range(1) ? CHAR_STAR : CHAR_SLASH);
               if ($urandom_range(3) == 0) s.push_back(random_sign());
            end
            digits = ($urandom_range(11) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
            repeat (digits) s.push_back(8'(CHAR_0 + $urandom_range(9)));
            if ($urandom_range(15) == 0) s.push_back(8'($urandom_range(255)));
         end
      end
      return s;
   endfunction

   // Broken sequence: operators and digits in any order, mixed with any code.
   function automatic char_q_type broken_sequence();
      char_q_type s;
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         case ($urandom_range(3))
            0: s.push_back(8'($urandom_range(255)));
            1: s.push_back(8'(CHAR_0 + $urandom_range(9)));
            2: s.push_back($urandom_range(1) ? CHAR_STAR : CHAR_SLASH);
            default: s.push_back(random_sign());
         endcase
      end
      return s;
   endfunction

   // Offer one character and hold it until it transfers. Drop valid for a
   // random gap first, never lowering and raising it within one edge.
   task automatic offer(input logic [7:0] code, input logic is_last,
                        input logic typed, input rsp_payload_type want);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= '{char_code: code, last: is_last};
      cur_typed   <= typed;
      cur_want    <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input char_q_type text);
      foreach (text[i]) offer(text[i], i == text.size() - 1, 1'b0, NO_RSP);
   endtask

   initial begin : stimulus
      char_q_type text;
      int         sent;
      int         phase;

      // Directed rows: extreme and ignored codes, every operator, a sign after
      // * and after /, repeated + and -, division by zero of either sign, and a
      // number with too many digits.
      probes = '{
         '{8'h00,      1'b0, 1'b0, NO_RSP},
         '{8'hFF,      1'b0, 1'b0, NO_RSP},
         '{"7",        1'b1, 1'b1, '{48'h0000_0007_0000, 1'b0, 1'b0}},
         '{"8",        1'b0, 1'b0, NO_RSP},
         '{CHAR_SLASH, 1'b0, 1'b0, NO_RSP},
         '{CHAR_MINUS, 1'b0, 1'b0, NO_RSP},
         '{"0",        1'b1, 1'b1, '{MAX_POS, 1'b1, 1'b0}},
         '{CHAR_MINUS, 1'b0, 1'b0, NO_RSP},
         '{"6",        1'b0, 1'b0, NO_RSP},
         '{CHAR_SLASH, 1'b0, 1'b0, NO_RSP},
         '{"0",        1'b1, 1'b1, '{MIN_NEG, 1'b1, 1'b0}},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{CHAR_PLUS,  1'b0, 1'b0, NO_RSP},
         '{CHAR_MINUS, 1'b0, 1'b0, NO_RSP},
         '{"2",        1'b0, 1'b0, NO_RSP},
         '{CHAR_STAR,  1'b0, 1'b0, NO_RSP},
         '{CHAR_PLUS,  1'b0, 1'b0, NO_RSP},
         '{"3",        1'b1, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b0, 1'b0, NO_RSP},
         '{"9",        1'b1, 1'b1, '{MAX_POS, 1'b0, 1'b1}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i]) offer(probes[i].code, probes[i].is_last, probes[i].typed,
                                probes[i].want);
      sent = $size(probes);

      // Random part in three phases: sender idles lightly and receiver heavily,
      // then the other way round, then neither idles. The last phase opens with
      // a long receiver hold-off so the block backs up into its input.
      while (sent < ITEM_TARGET) begin
         phase = sent * 3 / ITEM_TARGET;
         if (phase == 0) begin
            send_idle_pct = 30;
         end else if (phase == 1) begin
            send_idle_pct = 72;
            take_idle_pct <= 30;
         end else begin
            send_idle_pct = 0;
            take_idle_pct <= 0;
            hold_ask      <= 1'b1;
         end
         text = ($urandom_range(4) == 0) ? broken_sequence() : random_expression();
         send_text(text);
         sent += text.size();
      end
      req_valid <= 1'b0;

      // Drain: wait for every outstanding result, then a margin for strays.
      while (expression_values.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fails == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Receiver: random stalls per phase, plus one long hold-off counted here.
   always @(posedge clock) begin : rsp_side
      if (hold_ask && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < take_idle_pct);
      end
   end

   // Feed every accepted character to the evaluator.
   always @(posedge clock) begin : req_monitor
      if (!reset && req_valid && !req_stall) begin
         evaluate_char(req_payload.char_code, req_payload.last, cur_typed, cur_want);
      end
   end

   // Compare each result transfer with the oldest queued value.
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expression_values.size() == 0) begin
            fails++;
            $display("%0t: result with none queued: value %h div0 %b ovf %b", $time,
                     rsp_payload.value, rsp_payload.div_by_zero, rsp_payload.overflow);
         end else begin
            want = expression_values.pop_front();
            if (rsp_payload.value !== want.value ||
                rsp_payload.div_by_zero !== want.div_by_zero ||
                rsp_payload.overflow !== want.overflow) begin
               fails++;
               $display("%0t: mismatch: expected value %h div0 %b ovf %b, actual value %h div0 %b ovf %b",
                        $time, want.value, want.div_by_zero, want.overflow,
                        rsp_payload.value, rsp_payload.div_by_zero, rsp_payload.overflow);
            end
         end
      end
   end

   // Give up on a hung run.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expression_values.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// ===== infix_expression_evaluator.f =====
hdl/iee_pkg.sv
hdl/iee_muldiv.sv
hdl/iee_datapath.sv
hdl/iee_ctrl.sv
hdl/infix_expression_evaluator.sv
tb/infix_expression_evaluator_tb.sv
